/* rtl/mcm_pkg.sv */
// Shared types and constants for the metronome click mixer.
package mcm_pkg;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 27;

    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLES_PER_BEAT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLICK_ENABLE     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLICK_LENGTH     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENVELOPE_STEP    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TONE_STEP_HIGH   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_TONE_STEP_LOW    = 3'd5;

    // Register widths.
    localparam int SPB_W        = 27;
    localparam int CLICK_W      = 12;
    localparam int STEP_W       = 23;
    localparam int BEAT_W       = 2;
    localparam int BEAT_PHASE_W = 28;

    // Register reset values.
    localparam logic [SPB_W-1:0]   SPB_RESET       = 27'd6144000;
    localparam logic [CLICK_W-1:0] CLICK_LEN_RESET = 12'd384;
    localparam logic [CLICK_W-1:0] ENV_STEP_RESET  = 12'd171;
    localparam logic [STEP_W-1:0]  STEP_HI_RESET   = 23'd349525;
    localparam logic [STEP_W-1:0]  STEP_LO_RESET   = 23'd69905;

    localparam logic [CLICK_W-1:0]      CLICK_MIN  = 12'd32;
    localparam logic [BEAT_W-1:0]       BEAT_RESET = 2'd3;
    localparam logic [BEAT_PHASE_W-1:0] PHASE_MAX  = 28'hFFFFFFF;
    localparam logic [BEAT_PHASE_W-1:0] ONE_SAMPLE = 28'd256;

    // Envelope, Q0.16 with one integer bit for unity.
    localparam int               ENV_W   = 17;
    localparam logic [ENV_W-1:0] ENV_ONE = 17'h10000;

    // Shared multiplier.
    localparam int MUL_A_W   = 32;
    localparam int MUL_B_W   = 18;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MAG_SPLIT = 30;

    // Sine table: Q0.15 magnitudes, pi/2 in Q30 for the elaboration-time series.
    localparam int          SINE_MAG_W  = 15;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic                  neg;
        logic [SINE_MAG_W-1:0] mag;
    } sine_t;

    typedef struct packed {
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BEAT,
        S_CLICK,
        S_ENV,
        S_SQUARE,
        S_HIGH,
        S_LOW,
        S_SUM,
        S_ABS,
        S_MAG_LO,
        S_MAG_HI,
        S_ROUND,
        S_FINISH
    } state_t;

endpackage

/* rtl/mcm_in_if.sv */
// Input channel: one stereo sample per transaction.
interface mcm_in_if #(
    parameter int SAMPLE_WIDTH = 24
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] left_in;
    logic signed [SAMPLE_WIDTH-1:0] right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink (input valid, input left_in, input right_in, output ready);
endinterface

/* rtl/mcm_out_if.sv */
// Output channel: mixed stereo sample and beat status per transaction.
interface mcm_out_if #(
    parameter int SAMPLE_WIDTH = 24
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] left_out;
    logic signed [SAMPLE_WIDTH-1:0] right_out;
    logic                           beat_start;
    logic [1:0]                     beat_number;

    modport source (output valid, output left_out, output right_out, output beat_start,
                    output beat_number, input ready);
    modport sink (input valid, input left_out, input right_out, input beat_start,
                  input beat_number, output ready);
endinterface

/* rtl/mcm_sine.sv */
// Quarter-wave sine table and quadrant folding.
module mcm_sine #(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int PHASE_WIDTH      = 24
) (
    input  logic [PHASE_WIDTH-1:0] phase,
    output mcm_pkg::sine_t         sine
);
    import mcm_pkg::*;

    localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH);
    localparam int FRAC_W  = PHASE_WIDTH - 2;
    localparam int SCALE_W = FRAC_W + IDX_W;

    logic [SINE_MAG_W-1:0] rom [SINE_TABLE_DEPTH];
    logic [1:0]            quad;
    logic [SCALE_W-1:0]    scaled;
    logic [IDX_W-1:0]      idx_raw;
    logic [IDX_W-1:0]      idx;

    // Build each entry at elaboration from a Taylor series in Q30.
    for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++)
    begin : g_entry
        localparam logic [63:0] X  = HALF_PI_Q30 * (2 * gi + 1) / (2 * SINE_TABLE_DEPTH);
        localparam logic [63:0] T1 = ((((X * X) >> 30) * X) >> 30) / 6;
        localparam logic [63:0] T2 = ((((T1 * X) >> 30) * X) >> 30) / 20;
        localparam logic [63:0] T3 = ((((T2 * X) >> 30) * X) >> 30) / 42;
        localparam logic [63:0] T4 = ((((T3 * X) >> 30) * X) >> 30) / 72;
        localparam logic [63:0] T5 = ((((T4 * X) >> 30) * X) >> 30) / 110;
        localparam logic [63:0] T6 = ((((T5 * X) >> 30) * X) >> 30) / 156;
        localparam logic [63:0] T7 = ((((T6 * X) >> 30) * X) >> 30) / 210;
        localparam logic [63:0] POS = X + T2 + T4 + T6;
        localparam logic [63:0] NEG = T1 + T3 + T5 + T7;
        localparam logic [63:0] S   = (POS > NEG) ? (POS - NEG) : 64'd0;
        localparam logic [63:0] ENTRY = (S * 64'd32767 + (64'd1 << 29)) >> 30;
        assign rom[gi] = ENTRY[SINE_MAG_W-1:0];
    end

    assign quad    = phase[PHASE_WIDTH-1 -: 2];
    assign scaled  = SCALE_W'(phase[FRAC_W-1:0]) * SCALE_W'(SINE_TABLE_DEPTH);
    assign idx_raw = scaled[SCALE_W-1:FRAC_W];

    // Mirror the index in the falling quadrants.
    assign idx = quad[0] ? (IDX_W'(SINE_TABLE_DEPTH - 1) - idx_raw) : idx_raw;

    assign sine.mag = rom[idx];
    assign sine.neg = quad[1];

endmodule

/* rtl/mcm_mul.sv */
// Shared unsigned multiplier with registered product.
module mcm_mul (
    input  logic                          clk,
    input  mcm_pkg::mul_req_t             req,
    output logic [mcm_pkg::MUL_P_W-1:0]   prod
);
    import mcm_pkg::*;

    logic [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= MUL_P_W'(req.a) * MUL_P_W'(req.b);
    end

    assign prod = prod_reg;

endmodule

/* rtl/metronome_click_mixer.sv */
// Metronome click mixer: adds a decaying sine click on each beat to a stereo stream.
// Each sample is taken one at a time. With the metronome off (samples_per_beat zero) a
// sample goes from acceptance straight to its result; with no click sounding, or with
// the click muted, it passes the beat and click states first; with an audible click, it
// waits on the single shared 32x18 multiplier, which the click uses six times in series
// (envelope decay, envelope square, high tone gain, accent gain, and two halves of the
// envelope scaling). The next sample is accepted once the result is in the output
// register, even if the sink has not taken it yet. Configuration writes take effect at
// once and belong only in idle periods.
module metronome_click_mixer #(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int SAMPLE_WIDTH     = 24,
    parameter int PHASE_WIDTH      = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [mcm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mcm_pkg::CFG_DATA_W-1:0]     cfg_data,
    mcm_in_if.sink                             in_ch,
    mcm_out_if.source                          out_ch
);
    import mcm_pkg::*;

    localparam int MIX_W  = SAMPLE_WIDTH + 16;
    localparam int MAG_W  = MIX_W - 1;
    localparam int TICK_W = SAMPLE_WIDTH + 1;
    localparam int SUM_W  = SAMPLE_WIDTH + 2;

    localparam logic [63:0] GAIN_HIGH = ((64'd34 << (SAMPLE_WIDTH - 1)) + 64'd50) / 64'd100;
    localparam logic [63:0] GAIN_LOW  = ((64'd22 << (SAMPLE_WIDTH - 1)) + 64'd50) / 64'd100;

    localparam logic signed [SUM_W-1:0] SAT_HI =
        SUM_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);
    localparam logic signed [TICK_W-1:0] TICK_HI = TICK_W'(SAT_HI);
    localparam logic signed [TICK_W-1:0] TICK_LO = TICK_W'(SAT_LO);

    // Configuration registers.
    logic [SPB_W-1:0]   spb_reg;
    logic               click_en_reg;
    logic [CLICK_W-1:0] click_len_reg;
    logic [CLICK_W-1:0] env_step_reg;
    logic [STEP_W-1:0]  step_hi_reg;
    logic [STEP_W-1:0]  step_lo_reg;

    // Sequencer and metronome state.
    state_t                  state_reg;
    state_t                  state_next;
    logic [BEAT_PHASE_W-1:0] beat_phase_reg;
    logic [CLICK_W-1:0]      click_pos_reg;
    logic [BEAT_W-1:0]       beat_cnt_reg;
    logic [PHASE_WIDTH-1:0]  hi_ph_reg;
    logic [PHASE_WIDTH-1:0]  lo_ph_reg;
    logic                    out_valid_reg;

    // Working registers.
    logic signed [SAMPLE_WIDTH-1:0] left_reg;
    logic signed [SAMPLE_WIDTH-1:0] right_reg;
    logic                           start_reg;
    sine_t                          sine_reg;
    logic                           sign_hi_reg;
    logic [ENV_W-1:0]               env2_reg;
    logic signed [MIX_W-1:0]        mix_reg;
    logic [MAG_W-1:0]               mag_reg;
    logic                           neg_reg;
    logic [63:0]                    acc_reg;
    logic signed [TICK_W-1:0]       tick_reg;

    // Output register.
    logic signed [SAMPLE_WIDTH-1:0] left_out_reg;
    logic signed [SAMPLE_WIDTH-1:0] right_out_reg;
    logic                           out_start_reg;
    logic [BEAT_W-1:0]              out_beat_reg;

    logic                    accept;
    logic                    finish_go;
    logic                    beat_due;
    logic [BEAT_PHASE_W-1:0] phase_sub;
    logic [BEAT_PHASE_W-1:0] phase_inc;
    logic [CLICK_W-1:0]      click_n;
    logic                    click_active;
    logic [32:0]             hi_ph_sum;
    logic [32:0]             lo_ph_sum;
    logic [23:0]             dec;
    logic [ENV_W-1:0]        env_now;
    logic [33:0]             sq_sum;
    logic signed [MIX_W-1:0] term_prod;
    logic signed [MIX_W-1:0] term_hi;
    logic signed [MIX_W-1:0] term_lo;
    logic [63:0]             total;
    logic [32:0]             rounded;
    logic [TICK_W-2:0]       tick_mag;
    logic signed [SUM_W-1:0] sum_l;
    logic signed [SUM_W-1:0] sum_r;
    logic signed [SAMPLE_WIDTH-1:0] sat_l;
    logic signed [SAMPLE_WIDTH-1:0] sat_r;

    mul_req_t               mul_req;
    logic [MUL_P_W-1:0]     prod;
    logic [PHASE_WIDTH-1:0] sine_phase;
    sine_t                  sine_now;

    mcm_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    mcm_sine #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .PHASE_WIDTH      (PHASE_WIDTH)
    ) u_sine (
        .phase (sine_phase),
        .sine  (sine_now)
    );

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spb_reg       <= SPB_RESET;
            click_en_reg  <= 1'b0;
            click_len_reg <= CLICK_LEN_RESET;
            env_step_reg  <= ENV_STEP_RESET;
            step_hi_reg   <= STEP_HI_RESET;
            step_lo_reg   <= STEP_LO_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SAMPLES_PER_BEAT: spb_reg       <= cfg_data[SPB_W-1:0];
                CFG_CLICK_ENABLE:     click_en_reg  <= cfg_data[0];
                CFG_CLICK_LENGTH:     click_len_reg <= cfg_data[CLICK_W-1:0];
                CFG_ENVELOPE_STEP:    env_step_reg  <= cfg_data[CLICK_W-1:0];
                CFG_TONE_STEP_HIGH:   step_hi_reg   <= cfg_data[STEP_W-1:0];
                CFG_TONE_STEP_LOW:    step_lo_reg   <= cfg_data[STEP_W-1:0];
                default:              ;
            endcase
        end
    end

    assign accept    = in_ch.valid && in_ch.ready;
    assign finish_go = (state_reg == S_FINISH) && (!out_valid_reg || out_ch.ready);

    assign beat_due  = beat_phase_reg >= BEAT_PHASE_W'(spb_reg);
    assign phase_sub = beat_phase_reg - BEAT_PHASE_W'(spb_reg);
    assign phase_inc = (beat_phase_reg > (PHASE_MAX - ONE_SAMPLE)) ? PHASE_MAX
                                                                    : beat_phase_reg + ONE_SAMPLE;

    assign click_n      = (click_len_reg < CLICK_MIN) ? CLICK_MIN : click_len_reg;
    assign click_active = click_pos_reg < click_n;

    assign hi_ph_sum = 33'(hi_ph_reg) + 33'(step_hi_reg);
    assign lo_ph_sum = 33'(lo_ph_reg) + 33'(step_lo_reg);

    // Envelope from the decay product, floored at zero.
    assign dec     = prod[23:0];
    assign env_now = (dec >= 24'(ENV_ONE)) ? '0 : ENV_W'(24'(ENV_ONE) - dec);
    assign sq_sum  = {1'b0, prod[32:0]} + 34'd32768;

    assign term_prod = signed'({1'b0, prod[MAG_W-1:0]});
    assign term_hi   = sign_hi_reg ? -term_prod : term_prod;
    assign term_lo   = sine_reg.neg ? -term_prod : term_prod;

    // Magnitude times envelope is hi * 2^30 + lo; round half up at bit 31.
    assign total    = acc_reg + (64'(prod) << MAG_SPLIT) + (64'd1 << 30);
    assign rounded  = total[63:31];
    assign tick_mag = rounded[TICK_W-2:0];

    assign sum_l = SUM_W'(left_reg) + SUM_W'(tick_reg);
    assign sum_r = SUM_W'(right_reg) + SUM_W'(tick_reg);
    assign sat_l = (sum_l > SAT_HI) ? SAMPLE_WIDTH'(SAT_HI) :
                   (sum_l < SAT_LO) ? SAMPLE_WIDTH'(SAT_LO) : SAMPLE_WIDTH'(sum_l);
    assign sat_r = (sum_r > SAT_HI) ? SAMPLE_WIDTH'(SAT_HI) :
                   (sum_r < SAT_LO) ? SAMPLE_WIDTH'(SAT_LO) : SAMPLE_WIDTH'(sum_r);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next = (spb_reg == '0) ? S_FINISH : S_BEAT;
                end
            end
            S_BEAT:   state_next = S_CLICK;
            S_CLICK:  state_next = (click_active && click_en_reg) ? S_ENV : S_FINISH;
            S_ENV:    state_next = S_SQUARE;
            S_SQUARE: state_next = S_HIGH;
            S_HIGH:   state_next = S_LOW;
            S_LOW:    state_next = S_SUM;
            S_SUM:    state_next = S_ABS;
            S_ABS:    state_next = S_MAG_LO;
            S_MAG_LO: state_next = S_MAG_HI;
            S_MAG_HI: state_next = S_ROUND;
            S_ROUND:  state_next = S_FINISH;
            S_FINISH:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, multiplier operands, sine phase select.
    always_comb
    begin
        in_ch.ready = 1'b0;
        mul_req     = '0;
        sine_phase  = hi_ph_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ch.ready = 1'b1;
            end
            S_ENV:
            begin
                mul_req.a = MUL_A_W'(click_pos_reg);
                mul_req.b = MUL_B_W'(env_step_reg);
            end
            S_SQUARE:
            begin
                mul_req.a = MUL_A_W'(env_now);
                mul_req.b = MUL_B_W'(env_now);
            end
            S_HIGH:
            begin
                mul_req.a  = GAIN_HIGH[MUL_A_W-1:0];
                mul_req.b  = MUL_B_W'(sine_reg.mag);
                sine_phase = lo_ph_reg;
            end
            S_LOW:
            begin
                mul_req.a = GAIN_LOW[MUL_A_W-1:0];
                mul_req.b = MUL_B_W'(sine_reg.mag);
            end
            S_MAG_LO:
            begin
                mul_req.a = MUL_A_W'(mag_reg[MAG_SPLIT-1:0]);
                mul_req.b = MUL_B_W'(env2_reg);
            end
            S_MAG_HI:
            begin
                mul_req.a = MUL_A_W'(mag_reg[MAG_W-1:MAG_SPLIT]);
                mul_req.b = MUL_B_W'(env2_reg);
            end
            default:
            begin
                in_ch.ready = 1'b0;
            end
        endcase
    end

    // Control and metronome state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            beat_phase_reg <= '0;
            click_pos_reg  <= CLICK_LEN_RESET;
            beat_cnt_reg   <= BEAT_RESET;
            hi_ph_reg      <= '0;
            lo_ph_reg      <= '0;
            start_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (accept)
            begin
                start_reg <= 1'b0;
            end

            // Restart the click on a new beat.
            if (state_reg == S_BEAT && beat_due)
            begin
                beat_phase_reg <= phase_sub;
                click_pos_reg  <= '0;
                hi_ph_reg      <= '0;
                lo_ph_reg      <= '0;
                beat_cnt_reg   <= beat_cnt_reg + 2'd1;
                start_reg      <= 1'b1;
            end

            if (state_reg == S_CLICK)
            begin
                beat_phase_reg <= phase_inc;
            end

            // Advance the click once per sample, audible or not.
            if ((state_reg == S_CLICK && click_active && !click_en_reg) ||
                state_reg == S_ROUND)
            begin
                click_pos_reg <= click_pos_reg + 12'd1;
                hi_ph_reg     <= hi_ph_sum[PHASE_WIDTH-1:0];
                lo_ph_reg     <= lo_ph_sum[PHASE_WIDTH-1:0];
            end

            if (finish_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            left_reg  <= in_ch.left_in;
            right_reg <= in_ch.right_in;
            tick_reg  <= '0;
        end

        case (state_reg)
            S_CLICK:
            begin
                tick_reg <= '0;
            end
            S_ENV:
            begin
                sine_reg <= sine_now;
            end
            S_HIGH:
            begin
                env2_reg    <= sq_sum[32:16];
                sign_hi_reg <= sine_reg.neg;
                sine_reg    <= sine_now;
            end
            S_LOW:
            begin
                mix_reg <= term_hi;
            end
            S_SUM:
            begin
                if (beat_cnt_reg == '0)
                begin
                    mix_reg <= mix_reg + term_lo;
                end
            end
            S_ABS:
            begin
                neg_reg <= mix_reg[MIX_W-1];
                mag_reg <= mix_reg[MIX_W-1] ? MAG_W'(-mix_reg) : MAG_W'(mix_reg);
            end
            S_MAG_HI:
            begin
                acc_reg <= 64'(prod);
            end
            S_ROUND:
            begin
                tick_reg <= neg_reg ? -signed'({1'b0, tick_mag}) : signed'({1'b0, tick_mag});
            end
            default:
            begin
            end
        endcase

        if (finish_go)
        begin
            left_out_reg  <= sat_l;
            right_out_reg <= sat_r;
            out_start_reg <= start_reg;
            out_beat_reg  <= beat_cnt_reg;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.left_out    = left_out_reg;
    assign out_ch.right_out   = right_out_reg;
    assign out_ch.beat_start  = out_start_reg;
    assign out_ch.beat_number = out_beat_reg;

    // One sample in flight at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ch.ready)
        else $error("sample accepted while another is in work");

    // Squared envelope never exceeds unity.
    a_env2_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LOW |-> env2_reg <= ENV_ONE)
        else $error("squared envelope out of range");

    // Click value stays inside the sample range.
    a_tick_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FINISH |-> (tick_reg <= TICK_HI && tick_reg >= TICK_LO))
        else $error("click value out of sample range");

    // Hold a finished result while the previous one is still waiting.
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && out_valid_reg && !out_ch.ready) |=> state_reg == S_FINISH)
        else $error("result overwrote a pending output");

    // Metronome off passes straight through without a beat.
    a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && spb_reg == '0) |=> (state_reg == S_FINISH && !start_reg))
        else $error("bypass sample took the metronome path");

endmodule
